>>> sv/cidr_pkg.sv
// shared types, constants and mask helpers for the cidr address filter table
// no dependencies; imported by cidr_front, cidr_back and the top level
package cidr_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // command queue between front and back, depth must be a power of two
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] V4_MAX_LEN = 8'd32;
    localparam logic [7:0] V6_MAX_LEN = 8'd128;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic        func;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
    } req_t;

    typedef struct packed {
        logic matched;
        logic stored;
    } rsp_t;

    // classified item handed from front to back
    typedef struct packed {
        logic         func;
        logic         is_v6;
        logic [127:0] addr;
        logic [7:0]   plen;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] value;
    } v4_ent_t;

    typedef struct packed {
        logic [7:0]   len;
        logic [127:0] value;
    } v6_ent_t;

    // top n bits set, n in 0..32
    function automatic logic [31:0] mask32(input logic [5:0] n);
        return ~(32'hFFFF_FFFF >> n);
    endfunction

    // top n bits set, n in 0..128
    function automatic logic [127:0] mask128(input logic [7:0] n);
        return ~({128{1'b1}} >> n);
    endfunction

endpackage

>>> sv/cidr_front.sv
// front part: takes items, clamps the prefix length, masks add addresses
// and holds them in a short command queue; depends on cidr_pkg
module cidr_front
    import cidr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic cmd_valid,
    output cmd_t cmd,
    input  logic cmd_take
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic [CMDQ_CNT_W-1:0] cnt_next;
    logic                  do_push;
    logic                  do_pop;
    logic [7:0]            plen;
    logic [127:0]          addr;
    cmd_t                  cls;

    always_comb
    begin
        if (req.is_v6)
        begin
            plen = (req.prefix_len > V6_MAX_LEN) ? V6_MAX_LEN : req.prefix_len;
            addr = {req.addr_hi, req.addr_lo};
            if (req.func == FUNC_ADD)
            begin
                addr = addr & mask128(plen);
            end
        end
        else
        begin
            plen = (req.prefix_len > V4_MAX_LEN) ? V4_MAX_LEN : req.prefix_len;
            addr = {96'd0, req.addr_lo[31:0]};
            if (req.func == FUNC_ADD)
            begin
                addr = {96'd0, req.addr_lo[31:0] & mask32(plen[5:0])};
            end
        end
        cls.func  = req.func;
        cls.is_v6 = req.is_v6;
        cls.addr  = addr;
        cls.plen  = plen;
    end

    assign full      = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> sv/cidr_back.sv
// back part: prefix tables, add and one-entry-per-cycle lookup scan,
// and the result register; depends on cidr_pkg
module cidr_back
    import cidr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] v4_count_reg;
    logic [CNT_W-1:0] v4_count_next;
    logic [CNT_W-1:0] v6_count_reg;
    logic [CNT_W-1:0] v6_count_next;
    cmd_t             cur_reg;
    cmd_t             cur_next;
    rsp_t             pend_reg;
    rsp_t             pend_next;
    rsp_t             rs_reg;
    logic             rs_valid_reg;
    logic             rs_load;

    v4_ent_t          v4_mem [TABLE_DEPTH];
    v6_ent_t          v6_mem [TABLE_DEPTH];
    v4_ent_t          v4_rd_reg;
    v6_ent_t          v6_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             v4_we;
    logic             v6_we;

    logic [CNT_W-1:0] cur_count;
    logic [CNT_W-1:0] idx_inc;
    logic             hit;
    logic             last;

    assign cur_count = cur_reg.is_v6 ? v6_count_reg : v4_count_reg;
    assign idx_inc   = CNT_W'(idx_reg) + 1'b1;
    assign last      = (idx_inc == cur_count);
    assign hit       = cur_reg.is_v6
                     ? ((cur_reg.addr & mask128(v6_rd_reg.len)) == v6_rd_reg.value)
                     : ((cur_reg.addr[31:0] & mask32(v4_rd_reg.len)) == v4_rd_reg.value);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        v4_count_next = v4_count_reg;
        v6_count_next = v6_count_reg;
        cur_next      = cur_reg;
        pend_next     = pend_reg;
        cmd_take      = 1'b0;
        rd_addr       = '0;
        v4_we         = 1'b0;
        v6_we         = 1'b0;
        rs_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take          = 1'b1;
                    cur_next          = cmd;
                    idx_next          = '0;
                    pend_next.matched = 1'b0;
                    pend_next.stored  = 1'b0;
                    state_next        = S_FIN;
                    if (cmd.func == FUNC_ADD)
                    begin
                        if (cmd.is_v6)
                        begin
                            if (v6_count_reg != CNT_W'(TABLE_DEPTH))
                            begin
                                v6_we            = 1'b1;
                                v6_count_next    = v6_count_reg + 1'b1;
                                pend_next.stored = 1'b1;
                            end
                        end
                        else if (v4_count_reg != CNT_W'(TABLE_DEPTH))
                        begin
                            v4_we            = 1'b1;
                            v4_count_next    = v4_count_reg + 1'b1;
                            pend_next.stored = 1'b1;
                        end
                    end
                    else if ((cmd.is_v6 ? v6_count_reg : v4_count_reg) != '0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read of the next entry goes out while this one is compared
                rd_addr = idx_inc[IDX_W-1:0];
                if (hit || last)
                begin
                    pend_next.matched = hit;
                    state_next        = S_FIN;
                end
                else
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            S_FIN:
            begin
                if (!rs_valid_reg || pop)
                begin
                    rs_load    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            v4_count_reg <= '0;
            v6_count_reg <= '0;
            rs_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            v4_count_reg <= v4_count_next;
            v6_count_reg <= v6_count_next;
            if (rs_load)
            begin
                rs_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                rs_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        if (rs_load)
        begin
            rs_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_we)
        begin
            v4_mem[v4_count_reg[IDX_W-1:0]] <= '{len: cmd.plen[5:0], value: cmd.addr[31:0]};
        end
        v4_rd_reg <= v4_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (v6_we)
        begin
            v6_mem[v6_count_reg[IDX_W-1:0]] <= '{len: cmd.plen, value: cmd.addr};
        end
        v6_rd_reg <= v6_mem[rd_addr];
    end

    assign empty = !rs_valid_reg;
    assign rsp   = rs_reg;

endmodule

>>> sv/cidr_address_filter_table_top.sv
// an add goes from S_IDLE to S_FIN and then into the result register; a lookup
// scans n entries in S_SCAN on the way (stops at the first hit, at most
// TABLE_DEPTH); either may also wait in the command queue or for the result slot
// to be popped; the back end takes one item at a time, and a lookup scans one
// stored entry per cycle, set by the single read port of each table
// reset: rst_n clears both entry counts, the command queue and the valid flag
// of the result register; table contents and the result value are not cleared
module cidr_address_filter_table_top
    import cidr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    cidr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    cidr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for cidr_address_filter_table_top: prefix adds and lookups
// against a behavioral copy of both prefix tables; needs cidr_pkg and the rtl
module tb;
    import cidr_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned TAIL_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;

    class filter_scoreboard;
        logic [31:0]  v4_net [TABLE_DEPTH];
        logic [5:0]   v4_len [TABLE_DEPTH];
        int unsigned  v4_used;
        logic [127:0] v6_net [TABLE_DEPTH];
        logic [7:0]   v6_len [TABLE_DEPTH];
        int unsigned  v6_used;
        rsp_t         owed_verdicts [$];
        int unsigned  wrong_count;

        function new();
            v4_used = 0;
            v6_used = 0;
            wrong_count = 0;
        endfunction

        static function logic [31:0] v4_top_mask(int unsigned n);
            if (n == 0)
                return '0;
            return 32'hFFFF_FFFF << (32 - n);
        endfunction

        static function logic [127:0] v6_top_mask(int unsigned n);
            if (n == 0)
                return '0;
            return {128{1'b1}} << (128 - n);
        endfunction

        // updates the tables and returns the verdict the block owes
        function rsp_t predict_verdict(req_t r);
            rsp_t         v;
            int unsigned  n;
            logic [127:0] a6;
            v = '0;
            a6 = {r.addr_hi, r.addr_lo};
            if (r.func == FUNC_ADD) begin
                if (!r.is_v6) begin
                    n = (r.prefix_len > V4_MAX_LEN) ? V4_MAX_LEN : r.prefix_len;
                    if (v4_used < TABLE_DEPTH) begin
                        v4_len[v4_used] = 6'(n);
                        v4_net[v4_used] = r.addr_lo[31:0] & v4_top_mask(n);
                        v4_used++;
                        v.stored = 1'b1;
                    end
                end
                else begin
                    n = (r.prefix_len > V6_MAX_LEN) ? V6_MAX_LEN : r.prefix_len;
                    if (v6_used < TABLE_DEPTH) begin
                        v6_len[v6_used] = 8'(n);
                        v6_net[v6_used] = a6 & v6_top_mask(n);
                        v6_used++;
                        v.stored = 1'b1;
                    end
                end
            end
            else if (!r.is_v6) begin
                for (int unsigned i = 0; i < v4_used && !v.matched; i++)
                    if ((r.addr_lo[31:0] & v4_top_mask(v4_len[i])) == v4_net[i])
                        v.matched = 1'b1;
            end
            else begin
                for (int unsigned i = 0; i < v6_used && !v.matched; i++)
                    if ((a6 & v6_top_mask(v6_len[i])) == v6_net[i])
                        v.matched = 1'b1;
            end
            return v;
        endfunction

        function void note_request(req_t r);
            owed_verdicts.push_back(predict_verdict(r));
        endfunction

        function void check_verdict(rsp_t got);
            rsp_t want;
            if (owed_verdicts.size() == 0) begin
                wrong_count++;
                if (wrong_count <= MAX_REPORTS)
                    $display("unexpected result: matched=%0b stored=%0b",
                             got.matched, got.stored);
                return;
            end
            want = owed_verdicts.pop_front();
            if (got.matched !== want.matched || got.stored !== want.stored) begin
                wrong_count++;
                if (wrong_count <= MAX_REPORTS)
                    $display("mismatch: expected matched=%0b stored=%0b, got matched=%0b stored=%0b",
                             want.matched, want.stored, got.matched, got.stored);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    req_t req = '0;
    logic full;
    logic empty;
    rsp_t rsp;

    filter_scoreboard book = new();
    int send_calm = 0;

    cidr_address_filter_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int unsigned pick_gap(inout int calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic req_t make_req(logic f, logic v6, logic [63:0] hi,
                                      logic [63:0] lo, logic [7:0] len);
        req_t r;
        r.func = f;
        r.is_v6 = v6;
        r.addr_hi = hi;
        r.addr_lo = lo;
        r.prefix_len = len;
        return r;
    endfunction

    function automatic req_t random_add(bit v6);
        req_t r;
        int unsigned p;
        r = make_req(FUNC_ADD, v6, {$urandom, $urandom}, {$urandom, $urandom}, '0);
        p = $urandom_range(0, 99);
        if (p < 8)
            r.prefix_len = 8'(v6 ? $urandom_range(129, 255) : $urandom_range(33, 255));
        else if (p < 16)
            r.prefix_len = v6 ? V6_MAX_LEN : V4_MAX_LEN;
        else if (p < 17)
            r.prefix_len = 8'(v6 ? $urandom_range(1, 15) : $urandom_range(1, 7));
        else
            r.prefix_len = 8'(v6 ? $urandom_range(24, 127) : $urandom_range(12, 31));
        return r;
    endfunction

    // lookups mostly aimed at a stored prefix, some one bit off inside it
    function automatic req_t lookup_for(bit v6);
        req_t         r;
        int unsigned  pick, used, idx, len;
        logic [127:0] a6, m6;
        logic [31:0]  a4, m4;
        r = make_req(FUNC_LOOKUP, v6, {$urandom, $urandom}, {$urandom, $urandom},
                     8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        used = v6 ? book.v6_used : book.v4_used;
        if (used == 0 || pick >= 75)
            return r;
        idx = $urandom_range(0, used - 1);
        if (v6)
        begin
            len = book.v6_len[idx];
            m6 = filter_scoreboard::v6_top_mask(len);
            a6 = (book.v6_net[idx] & m6) | ({r.addr_hi, r.addr_lo} & ~m6);
            if (pick >= 45 && len > 0)
                a6[127 - $urandom_range(0, len - 1)] ^= 1'b1;
            {r.addr_hi, r.addr_lo} = a6;
        end
        else
        begin
            len = book.v4_len[idx];
            m4 = filter_scoreboard::v4_top_mask(len);
            a4 = (book.v4_net[idx] & m4) | (r.addr_lo[31:0] & ~m4);
            if (pick >= 45 && len > 0)
                a4[31 - $urandom_range(0, len - 1)] ^= 1'b1;
            r.addr_lo[31:0] = a4;
        end
        return r;
    endfunction

    function automatic req_t random_request();
        bit v6;
        v6 = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 35)
            return random_add(v6);
        return lookup_for(v6);
    endfunction

    task automatic send_item(req_t item);
        int unsigned gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        book.note_request(item);
    endtask

    // stop offering while waiting so the last item is not taken twice
    task automatic wait_drained();
        push <= 1'b0;
        while (book.owed_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // lookups into empty tables
        send_item(make_req(FUNC_LOOKUP, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 8'h00));
        // ipv4 adds: host bits and the unused upper bits must be dropped
        send_item(make_req(FUNC_ADD, 1'b0, 64'hDEAD_BEEF_0000_0001,
                           64'hFFFF_FFFF_0A12_3456, 8'd8));
        send_item(make_req(FUNC_ADD, 1'b0, '0, 64'h0000_0000_C0A8_0105, 8'd255));
        send_item(make_req(FUNC_ADD, 1'b0, '0, 64'h0000_0000_FFFF_FFFF, 8'd32));
        send_item(make_req(FUNC_ADD, 1'b0, '0, 64'h0000_0000_0000_0001, 8'd33));
        send_item(make_req(FUNC_ADD, 1'b0, '0, 64'h0000_0000_0A00_0000, 8'd8));
        send_item(make_req(FUNC_LOOKUP, 1'b0, '0, 64'h0000_0000_0AFF_FFFF, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b0, '0, 64'h0000_0000_0B00_0000, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b0, '0, 64'h0000_0000_C0A8_0105, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b0, '0, 64'h0000_0000_C0A8_0104, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b0, '0, 64'h0000_0000_0000_0001, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_0000_0000, 8'd0));
        // ipv6 adds around the 64 bit boundary and oversized lengths
        send_item(make_req(FUNC_ADD, 1'b1, 64'h2001_0DB8_FFFF_1234,
                           64'h5555_AAAA_5555_AAAA, 8'd32));
        send_item(make_req(FUNC_ADD, 1'b1, 64'hFE80_0000_0000_0000,
                           64'h0123_4567_89AB_CDEF, 8'd64));
        send_item(make_req(FUNC_ADD, 1'b1, 64'h1111_1111_1111_1111,
                           64'hC000_0000_0000_0001, 8'd65));
        send_item(make_req(FUNC_ADD, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 8'd128));
        send_item(make_req(FUNC_ADD, 1'b1, '0, 64'h0000_0000_0000_0001, 8'd129));
        send_item(make_req(FUNC_ADD, 1'b1, 64'h0123_4567_89AB_CDEF,
                           64'hFEDC_BA98_7654_3210, 8'd255));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000,
                           {$urandom, $urandom}, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'hFE80_0000_0000_0000,
                           {$urandom, $urandom}, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'h1111_1111_1111_1111,
                           64'h8765_4321_0FED_CBA9, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'h1111_1111_1111_1111,
                           64'h7FFF_FFFF_FFFF_FFFF, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, '0, 64'h0000_0000_0000_0001, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, '0, '0, 8'd0));
        send_item(make_req(FUNC_LOOKUP, 1'b1, 64'h0123_4567_89AB_CDEF,
                           64'hFEDC_BA98_7654_3211, 8'd0));
    endtask

    // fill one family to its last slot, put a zero-length prefix there,
    // then add into the full table
    task automatic close_family(bit v6);
        req_t r;
        while ((v6 ? book.v6_used : book.v4_used) < TABLE_DEPTH - 1)
            send_item(random_add(v6));
        repeat (3) send_item(lookup_for(v6));
        r = random_add(v6);
        r.prefix_len = '0;
        send_item(r);
        repeat (3) send_item(lookup_for(v6));
        repeat (2) send_item(random_add(v6));
        r = random_add(v6);
        r.prefix_len = 8'hFF;
        send_item(r);
        send_item(lookup_for(v6));
    endtask

    initial
    begin : stimulus
        int unsigned k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            send_item(random_request());
        end
        close_family(1'b0);
        close_family(1'b1);
        repeat (4) send_item(lookup_for(1'b0));
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.wrong_count == 0 && book.owed_verdicts.size() == 0)
            $display("cidr_address_filter_table_top verification clean");
        else
            $display("cidr_address_filter_table_top verification failed");
        $finish;
    end

    initial
    begin : drain_side
        int          calm;
        int unsigned gap;
        int unsigned seen;
        bit          held;
        calm = 0;
        seen = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // one long hold-off so the block backs up and raises full
            if (!held && seen == 400)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap(calm);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            book.check_verdict(rsp);
            seen++;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("cidr_address_filter_table_top verification failed");
        $finish;
    end

endmodule
